[sv/lmrq_pkg.sv]
// Shared constants, codes and types of the line message receive queue.
package lmrq_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int OFFSET_W     = 6;
    localparam int BYTE_W       = 8;

    localparam logic [PTR_W-1:0]  FULL_PTR = PTR_W'(BUFFER_DEPTH);
    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

    typedef enum logic [1:0] {
        FUNC_RECEIVE = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_DELETE  = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_SHIFT = 2'd2
    } state_t;

    // Broadcast to every cell of the byte chain
    typedef struct packed {
        logic              shift;
        logic              wr_en;
        logic [PTR_W-1:0]  wr_ptr;
        logic [BYTE_W-1:0] wr_data;
        logic [PTR_W-1:0]  rd_ptr;
        logic [PTR_W-1:0]  shift_lim;
    } cell_ctrl_t;

endpackage

[sv/lmrq_cell.sv]
// One byte cell of the message chain: load, shift toward the head, read select.
module lmrq_cell (
    input  logic                            clk,
    input  lmrq_pkg::cell_ctrl_t            ctrl,
    input  logic [lmrq_pkg::PTR_W-1:0]      my_index,
    input  logic [lmrq_pkg::BYTE_W-1:0]     right_data,
    input  logic [lmrq_pkg::BYTE_W-1:0]     tail_data,
    output logic [lmrq_pkg::BYTE_W-1:0]     data,
    output logic [lmrq_pkg::BYTE_W-1:0]     rd_data
);
    import lmrq_pkg::*;

    logic [BYTE_W-1:0] data_reg;
    logic [PTR_W-1:0]  next_index;

    assign next_index = my_index + PTR_W'(1);

    // On a shift take the neighbor's byte below the limit, the tail byte at it,
    // and hold above it; otherwise load the new character when addressed
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            if (next_index < ctrl.shift_lim)
            begin
                data_reg <= right_data;
            end
            else if (next_index == ctrl.shift_lim)
            begin
                data_reg <= tail_data;
            end
        end
        else if (ctrl.wr_en && (ctrl.wr_ptr == my_index))
        begin
            data_reg <= ctrl.wr_data;
        end
    end

    assign data    = data_reg;
    // Drive the read bus only when addressed
    assign rd_data = (ctrl.rd_ptr == my_index) ? data_reg : '0;

endmodule

[sv/line_message_receive_queue_core.sv]
// Top level of the line message receive queue: control and the chain of byte cells.
//
// Usage: each input item carries func (0 receive a character, 1 read the byte at
// read_offset, 2 delete the oldest complete message, 3 status only) with rx_byte
// and read_offset. Every input item yields exactly one result item with
// read_data, message_done, pending and overflowed.
// Receive, read and status items, and a delete while no complete message is held,
// finish without a walk: the result is registered and offered the cycle after
// acceptance. Any other delete first walks the oldest message one byte per cycle
// to find its length len, then shifts the cells below the last len cells one place
// toward the head per cycle, len times, while the last len cells keep their bytes;
// its result is registered as the last shift is made.
// The block works on one item at a time; a new item is taken while the previous
// result is being taken on the same edge.
// Reset clears the write position, the end of the complete region and the result
// valid flag; the byte cells are not cleared, as nothing reads them before write.
// When the receiver stalls, the result register holds and in_ready stays low.
module line_message_receive_queue_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      func,
    input  logic [lmrq_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [lmrq_pkg::OFFSET_W-1:0]   read_offset,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lmrq_pkg::BYTE_W-1:0]     read_data,
    output logic                            message_done,
    output logic                            pending,
    output logic                            overflowed
);
    import lmrq_pkg::*;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   ce_reg, ce_next;
    logic [PTR_W-1:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0]   len_reg, len_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  read_data_reg, read_data_next;
    logic               done_reg, done_next;
    logic               pending_reg, pending_next;
    logic               overflowed_reg, overflowed_next;

    cell_ctrl_t         ctrl;
    logic [BYTE_W-1:0]  cell_data [BUFFER_DEPTH];
    logic [BYTE_W-1:0]  cell_rd   [BUFFER_DEPTH];
    logic [BYTE_W-1:0]  rd_bus;
    logic               is_term;
    logic               accept;
    logic               finish;

    // Byte chain: cell 0 holds the oldest byte, shifts pull from the right
    for (genvar i = 0; i < BUFFER_DEPTH; i++)
    begin : g_cell
        logic [BYTE_W-1:0] right;
        if (i == BUFFER_DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cell_data[i+1];
        end
        lmrq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .my_index   (PTR_W'(i)),
            .right_data (right),
            .tail_data  (rd_bus),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    // Combine the read bus
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < BUFFER_DEPTH; i++)
        begin
            rd_bus = rd_bus | cell_rd[i];
        end
    end

    assign is_term  = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF) || (rx_byte == CHAR_NUL);
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Cell controls: write on a stored character, read address per phase
    always_comb
    begin
        ctrl.shift     = (state_reg == ST_SHIFT);
        ctrl.wr_en     = accept && (func_t'(func) == FUNC_RECEIVE) && (wp_reg != FULL_PTR);
        ctrl.wr_ptr    = wp_reg;
        ctrl.wr_data   = is_term ? CHAR_NUL : rx_byte;
        ctrl.shift_lim = FULL_PTR - len_reg;
        unique case (state_reg)
            ST_SCAN:
            begin
                ctrl.rd_ptr = cnt_reg;
            end
            ST_SHIFT:
            begin
                // Fetch the tail byte that lands on the last moving cell
                ctrl.rd_ptr = FULL_PTR - len_reg - PTR_W'(1) + cnt_reg;
            end
            default:
            begin
                ctrl.rd_ptr = PTR_W'(read_offset);
            end
        endcase
    end

    // Next state, pointers and result
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        ce_next         = ce_reg;
        cnt_next        = cnt_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_data_next  = read_data_reg;
        done_next       = done_reg;
        finish          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    read_data_next = '0;
                    done_next      = 1'b0;
                    finish         = 1'b1;
                    unique case (func_t'(func))
                        FUNC_RECEIVE:
                        begin
                            if (wp_reg == FULL_PTR)
                            begin
                                // Drop the character; a terminator discards the message
                                if (is_term)
                                begin
                                    wp_next = ce_reg;
                                end
                            end
                            else
                            begin
                                wp_next = wp_reg + PTR_W'(1);
                                if (is_term)
                                begin
                                    ce_next   = wp_reg + PTR_W'(1);
                                    done_next = 1'b1;
                                end
                            end
                        end
                        FUNC_READ:
                        begin
                            if (PTR_W'(read_offset) < wp_reg)
                            begin
                                read_data_next = rd_bus;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (ce_reg != '0)
                            begin
                                finish     = 1'b0;
                                cnt_next   = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_NONE:
                        begin
                            read_data_next = '0;
                        end
                        default:
                        begin
                            read_data_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Walk the oldest message up to its terminator or the complete end
                if ((rd_bus == CHAR_NUL) || (cnt_reg + PTR_W'(1) == ce_reg))
                begin
                    len_next   = cnt_reg + PTR_W'(1);
                    cnt_next   = PTR_W'(1);
                    state_next = ST_SHIFT;
                end
                else
                begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            ST_SHIFT:
            begin
                // Advance the chain by one byte; finish after len shifts
                if (cnt_reg == len_reg)
                begin
                    ce_next = ce_reg - len_reg;
                    if (wp_reg != FULL_PTR)
                    begin
                        wp_next = wp_reg - len_reg;
                    end
                    state_next = ST_IDLE;
                    finish     = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        pending_next    = finish ? (ce_next != '0) : pending_reg;
        overflowed_next = finish ? (wp_next == FULL_PTR) : overflowed_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            ce_reg        <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            ce_reg        <= ce_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        read_data_reg  <= read_data_next;
        done_reg       <= done_next;
        pending_reg    <= pending_next;
        overflowed_reg <= overflowed_next;
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign message_done = done_reg;
    assign pending      = pending_reg;
    assign overflowed   = overflowed_reg;

endmodule
